[src/grover_state_vector_engine_assert.svh]
// Assertion macros used by the checker file of the state-vector engine.
// Depends on nothing; each macro samples on the given clock, reset active low.
`ifndef GROVER_STATE_VECTOR_ENGINE_ASSERT_SVH
`define GROVER_STATE_VECTOR_ENGINE_ASSERT_SVH

// Same-cycle implication
`define GSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsv assertion failed");

// Next-cycle implication
`define GSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsv assertion failed");

`endif

[src/gsv_pkg.sv]
// Package of the state-vector engine: field widths, codes, command types.
// Depends on nothing.
package gsv_pkg;

    localparam int DEF_MAX_QUBITS    = 10;
    localparam int DEF_AMP_FRAC_BITS = 14;

    localparam int MODE_W = 3;
    localparam int POS_W  = 10;
    localparam int DRAW_W = 32;
    localparam int IDX_W  = 10;
    localparam int PROB_W = 29;
    localparam int QC_W   = 4;
    localparam int SQ_W   = 31;

    localparam logic [PROB_W-1:0] PROB_MAX      = {PROB_W{1'b1}};
    localparam int                INV_SQRT2_Q16 = 46341;
    localparam logic [QC_W-1:0]   QC_RESET      = QC_W'(1);

    localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HAD     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ORACLE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PHASE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEASURE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

    // Word index of the one configuration register
    localparam logic REG_QUBIT_COUNT = 1'b0;

    typedef enum logic [2:0] {
        WS_INIT,
        WS_SUM,
        WS_DIFF,
        WS_ABS,
        WS_ABSNEG,
        WS_NEG,
        WS_ZERO,
        WS_ONE
    } wsel_t;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        wsel_t wsel;
        logic  bfly_latch;
        logic  sq_latch;
        logic  acc_clr;
        logic  tot_acc;
        logic  run_acc;
        logic  prod_lo;
        logic  prod_hi;
        logic  prod_sum;
    } dp_cmd_t;

    // Rounded square root of 2^(2*frac-n), the uniform amplitude
    function automatic longint unsigned init_amp(int frac, int n);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = 64'd1 << (2 * frac - n);
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 64'd0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (x > r) r = r + 64'd1;
        return r;
    endfunction

endpackage

[src/gsv_cmd_if.sv]
// Command channel of the state-vector engine: valid, ready and one command.
// Depends on gsv_pkg.
interface gsv_cmd_if import gsv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DRAW_W-1:0] random_draw;

    modport source (output valid, mode, position, random_draw, input ready);
    modport sink   (input valid, mode, position, random_draw, output ready);
endinterface

[src/gsv_res_if.sv]
// Result channel of the state-vector engine: valid, ready and one result.
// Depends on gsv_pkg.
interface gsv_res_if import gsv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  measured_index;
    logic [PROB_W-1:0] probability;

    modport source (output valid, measured_index, probability, input ready);
    modport sink   (input valid, measured_index, probability, output ready);
endinterface

[src/gsv_cfg.sv]
// APB register block: holds qubit_count and derives the qubit count in effect.
// Depends on gsv_pkg.
module gsv_cfg
    import gsv_pkg::*;
#(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    localparam int NW = $clog2(MAX_QUBITS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output logic [NW-1:0] eff_n
);

    logic [QC_W-1:0] qc_reg;
    logic            wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_QUBIT_COUNT);

    // Hold the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qc_reg <= QC_RESET;
        else if (wr_hit)
            qc_reg <= pwdata[QC_W-1:0];
    end

    // Read back
    assign prdata = (paddr[2] == REG_QUBIT_COUNT) ? 32'(qc_reg) : 32'd0;

    // Clamp the count to 1..MAX_QUBITS
    always_comb
    begin
        if (qc_reg == '0)
            eff_n = NW'(1);
        else if (32'(qc_reg) > MAX_QUBITS)
            eff_n = NW'(MAX_QUBITS);
        else
            eff_n = NW'(qc_reg);
    end

endmodule

[src/gsv_dp.sv]
// Datapath: amplitude memory, butterfly, abs/negate, square, sums and compare.
// Depends on gsv_pkg; driven by gsv_ctrl through dp_cmd_t.
module gsv_dp
    import gsv_pkg::*;
#(
    parameter int MAX_QUBITS    = DEF_MAX_QUBITS,
    parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS,
    localparam int AW_A = MAX_QUBITS,
    localparam int NW   = $clog2(MAX_QUBITS + 1)
)
(
    input  logic              clk,
    input  dp_cmd_t           cmd,
    input  logic [AW_A-1:0]   rd_addr_a,
    input  logic [AW_A-1:0]   rd_addr_b,
    input  logic [AW_A-1:0]   wr_addr,
    input  logic [NW-1:0]     eff_n,
    input  logic [DRAW_W-1:0] draw,
    output logic              exceeds,
    output logic [PROB_W-1:0] prob
);

    localparam int AW     = AMP_FRAC_BITS + 2;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int BW     = AW + 1 + 18;
    localparam int SQ_SHR = (2 * AMP_FRAC_BITS >= 28) ? 2 * AMP_FRAC_BITS - 28 : 0;
    localparam int SQ_SHL = (2 * AMP_FRAC_BITS >= 28) ? 0 : 28 - 2 * AMP_FRAC_BITS;
    localparam int SQX_W  = 2 * AW + SQ_SHL;
    localparam int SUM_W  = SQ_W + MAX_QUBITS;
    localparam int PR_W   = 96;
    localparam logic signed [AW-1:0] AMP_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] AMP_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [AW-1:0] AMP_ONE = AW'(1) << AMP_FRAC_BITS;

    logic signed [AW-1:0]  mem [DEPTH];
    logic signed [AW-1:0]  rda_reg, rdb_reg;
    logic signed [AW-1:0]  s_reg, d_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [SUM_W-1:0]      tot_reg, run_reg;
    logic [63:0]           plo_reg, phi_reg;
    logic [PR_W-1:0]       prod_reg;
    logic signed [AW-1:0]  init_tab [MAX_QUBITS+1];
    logic signed [AW-1:0]  wr_data;
    logic signed [AW-1:0]  abs_a, absneg_a, neg_a;
    logic signed [AW:0]    bsum, bdiff;
    logic signed [BW-1:0]  bsum_p, bdiff_p;
    logic signed [AW-1:0]  bsum_sat, bdiff_sat;
    logic [AW-1:0]         mag_a;
    logic [2*AW-1:0]       sq_full;
    logic [SQX_W-1:0]      sq_wide;
    logic [SQ_W-1:0]       sq_scaled;
    logic [63:0]           tot64;
    logic [63:0]           pmul;

    function automatic logic signed [AW-1:0] sat_w(input logic signed [BW-1:0] v);
        if (v > BW'(AMP_MAX)) return AMP_MAX;
        if (v < BW'(AMP_MIN)) return AMP_MIN;
        return v[AW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] neg_sat(input logic signed [AW-1:0] v);
        if (v == AMP_MIN) return AMP_MAX;
        return -v;
    endfunction

    // Uniform amplitude per qubit count, fixed at elaboration
    for (genvar g = 0; g <= MAX_QUBITS; g++)
    begin : g_init
        assign init_tab[g] = AW'(init_amp(AMP_FRAC_BITS, g));
    end

    // Butterfly: (a +/- b) * 1/sqrt2 in Q16, round, floor shift, saturate
    assign bsum      = (AW+1)'(rda_reg) + (AW+1)'(rdb_reg);
    assign bdiff     = (AW+1)'(rda_reg) - (AW+1)'(rdb_reg);
    assign bsum_p    = ((BW'(bsum) * BW'(INV_SQRT2_Q16)) + BW'(32768)) >>> 16;
    assign bdiff_p   = ((BW'(bdiff) * BW'(INV_SQRT2_Q16)) + BW'(32768)) >>> 16;
    assign bsum_sat  = sat_w(bsum_p);
    assign bdiff_sat = sat_w(bdiff_p);

    // Abs and negate, saturating the most negative code
    assign abs_a    = rda_reg[AW-1] ? neg_sat(rda_reg) : rda_reg;
    assign absneg_a = neg_sat(abs_a);
    assign neg_a    = neg_sat(rda_reg);

    // Square scaled to Q3.28
    assign mag_a     = rda_reg[AW-1] ? AW'(-rda_reg) : AW'(rda_reg);
    assign sq_full   = (2*AW)'(mag_a) * (2*AW)'(mag_a);
    assign sq_wide   = SQX_W'(sq_full) << SQ_SHL;
    assign sq_scaled = SQ_W'(sq_wide >> SQ_SHR);

    // One 32x32 multiplier, shared by the two halves of draw * total
    assign tot64 = 64'(tot_reg);
    assign pmul  = 64'(draw) * 64'(cmd.prod_hi ? tot64[63:32] : tot64[31:0]);

    // Select write data
    always_comb
    begin
        case (cmd.wsel)
            WS_INIT:   wr_data = init_tab[eff_n];
            WS_SUM:    wr_data = s_reg;
            WS_DIFF:   wr_data = d_reg;
            WS_ABS:    wr_data = abs_a;
            WS_ABSNEG: wr_data = absneg_a;
            WS_NEG:    wr_data = neg_a;
            WS_ONE:    wr_data = AMP_ONE;
            default:   wr_data = '0;
        endcase
    end

    // Amplitude memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rda_reg <= mem[rd_addr_a];
            rdb_reg <= mem[rd_addr_b];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.bfly_latch)
        begin
            s_reg <= bsum_sat;
            d_reg <= bdiff_sat;
        end
        if (cmd.sq_latch)
            sq_reg <= sq_scaled;
        if (cmd.acc_clr)
        begin
            tot_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            if (cmd.tot_acc)
                tot_reg <= tot_reg + SUM_W'(sq_reg);
            if (cmd.run_acc)
                run_reg <= run_reg + SUM_W'(sq_reg);
        end
        if (cmd.prod_lo)
            plo_reg <= pmul;
        if (cmd.prod_hi)
            phi_reg <= pmul;
        if (cmd.prod_sum)
            prod_reg <= PR_W'(plo_reg) + (PR_W'(phi_reg) << 32);
    end

    // Status and query result
    assign exceeds = (PR_W'(run_reg) << 32) > prod_reg;
    assign prob    = (sq_reg > SQ_W'(PROB_MAX)) ? PROB_MAX : sq_reg[PROB_W-1:0];

endmodule

[src/gsv_ctrl.sv]
// Controller: sequences each command over the amplitude memory and holds the result.
// Depends on gsv_pkg, gsv_cmd_if, gsv_res_if; drives gsv_dp.
module gsv_ctrl
    import gsv_pkg::*;
#(
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    localparam int AW_A = MAX_QUBITS,
    localparam int NW   = $clog2(MAX_QUBITS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    gsv_cmd_if.sink           cmd,
    gsv_res_if.source         res,
    input  logic [NW-1:0]     eff_n,
    output dp_cmd_t           dcmd,
    output logic [AW_A-1:0]   rd_addr_a,
    output logic [AW_A-1:0]   rd_addr_b,
    output logic [AW_A-1:0]   wr_addr,
    output logic [DRAW_W-1:0] draw,
    input  logic              exceeds,
    input  logic [PROB_W-1:0] prob
);

    localparam int CW = MAX_QUBITS + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT_WR,
        ST_BF_RD, ST_BF_MUL, ST_BF_WA, ST_BF_WB,
        ST_EL_RD, ST_EL_WR,
        ST_T_RD, ST_T_SQ, ST_T_ACC,
        ST_P_LO, ST_P_HI, ST_P_SUM,
        ST_S_RD, ST_S_SQ, ST_S_ACC, ST_S_CMP,
        ST_C_WR, ST_Q_RD, ST_Q_SQ, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [NW-1:0]      s_reg;
    logic [AW_A-1:0]    k_reg;
    logic               res_valid_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [PROB_W-1:0]  res_prob_reg;

    logic [CW-1:0]      size, last_i, last_j;
    logic [CW-1:0]      lo_mask, hbit, ins, ins_b;
    logic               pos_hit, pos_in, out_free;
    logic [AW_A-1:0]    i_addr;

    assign size     = CW'(1) << eff_n;
    assign last_i   = size - CW'(1);
    assign last_j   = (size >> 1) - CW'(1);
    assign hbit     = CW'(1) << s_reg;
    assign lo_mask  = hbit - CW'(1);
    assign ins      = ((j_reg & ~lo_mask) << 1) | (j_reg & lo_mask);
    assign ins_b    = ins | hbit;
    assign i_addr   = i_reg[AW_A-1:0];
    assign pos_hit  = 32'(i_reg) == 32'(pos_reg);
    assign pos_in   = 32'(pos_reg) < 32'(size);
    assign out_free = !res_valid_reg || res.ready;

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign res.valid          = res_valid_reg;
    assign res.measured_index = res_idx_reg;
    assign res.probability    = res_prob_reg;
    assign draw               = draw_reg;

    // Memory addresses
    always_comb
    begin
        rd_addr_a = i_addr;
        rd_addr_b = i_addr;
        wr_addr   = i_addr;
        if (state_reg == ST_BF_RD || state_reg == ST_BF_WA)
        begin
            rd_addr_a = ins[AW_A-1:0];
            rd_addr_b = ins_b[AW_A-1:0];
            wr_addr   = ins[AW_A-1:0];
        end
        else if (state_reg == ST_BF_WB)
            wr_addr = ins_b[AW_A-1:0];
        else if (state_reg == ST_Q_RD)
            rd_addr_a = AW_A'(pos_reg);
    end

    // Datapath commands per state
    always_comb
    begin
        dcmd = '0;
        dcmd.wsel = WS_ZERO;
        unique case (state_reg)
            ST_IDLE:    dcmd.acc_clr = cmd.valid;
            ST_INIT_WR:
            begin
                dcmd.wr_en = 1'b1;
                dcmd.wsel  = WS_INIT;
            end
            ST_BF_RD:   dcmd.rd_en = 1'b1;
            ST_BF_MUL:  dcmd.bfly_latch = 1'b1;
            ST_BF_WA:
            begin
                dcmd.wr_en = 1'b1;
                dcmd.wsel  = WS_SUM;
            end
            ST_BF_WB:
            begin
                dcmd.wr_en = 1'b1;
                dcmd.wsel  = WS_DIFF;
            end
            ST_EL_RD:   dcmd.rd_en = 1'b1;
            ST_EL_WR:
            begin
                dcmd.wr_en = 1'b1;
                if (mode_reg == MODE_ORACLE)
                    dcmd.wsel = pos_hit ? WS_ABSNEG : WS_ABS;
                else
                    dcmd.wsel = WS_NEG;
            end
            ST_T_RD, ST_S_RD, ST_Q_RD: dcmd.rd_en = 1'b1;
            ST_T_SQ, ST_S_SQ, ST_Q_SQ: dcmd.sq_latch = 1'b1;
            ST_T_ACC:   dcmd.tot_acc = 1'b1;
            ST_P_LO:    dcmd.prod_lo = 1'b1;
            ST_P_HI:    dcmd.prod_hi = 1'b1;
            ST_P_SUM:   dcmd.prod_sum = 1'b1;
            ST_S_ACC:   dcmd.run_acc = 1'b1;
            ST_S_CMP:   ;
            ST_C_WR:
            begin
                dcmd.wr_en = 1'b1;
                dcmd.wsel  = (i_addr == k_reg) ? WS_ONE : WS_ZERO;
            end
            ST_DONE:    ;
            default:    dcmd = '0;
        endcase
    end

    // State, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            pos_reg       <= '0;
            draw_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_prob_reg  <= '0;
        end
        else
        begin
            // Drop the result once taken, unless a new one loads in its place
            if (res_valid_reg && res.ready && state_reg != ST_DONE)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        mode_reg <= cmd.mode;
                        pos_reg  <= cmd.position;
                        draw_reg <= cmd.random_draw;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        s_reg    <= '0;
                        k_reg    <= '0;
                        case (cmd.mode)
                            MODE_INIT:    state_reg <= ST_INIT_WR;
                            MODE_HAD:     state_reg <= ST_BF_RD;
                            MODE_ORACLE:  state_reg <= ST_EL_RD;
                            MODE_PHASE:
                            begin
                                i_reg     <= CW'(1);
                                state_reg <= ST_EL_RD;
                            end
                            MODE_MEASURE: state_reg <= ST_T_RD;
                            MODE_QUERY:
                                state_reg <= (32'(cmd.position) < 32'(size)) ? ST_Q_RD
                                                                             : ST_DONE;
                            default:      state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_INIT_WR:
                begin
                    i_reg <= i_reg + CW'(1);
                    if (i_reg == last_i)
                        state_reg <= ST_DONE;
                end
                ST_BF_RD:  state_reg <= ST_BF_MUL;
                ST_BF_MUL: state_reg <= ST_BF_WA;
                ST_BF_WA:  state_reg <= ST_BF_WB;
                ST_BF_WB:
                begin
                    // Advance pair, then stage
                    if (j_reg == last_j)
                    begin
                        j_reg <= '0;
                        if (32'(s_reg) == 32'(eff_n) - 1)
                            state_reg <= ST_DONE;
                        else
                        begin
                            s_reg     <= s_reg + NW'(1);
                            state_reg <= ST_BF_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= ST_BF_RD;
                    end
                end
                ST_EL_RD:  state_reg <= ST_EL_WR;
                ST_EL_WR:
                begin
                    i_reg <= i_reg + CW'(1);
                    state_reg <= (i_reg == last_i) ? ST_DONE : ST_EL_RD;
                end
                ST_T_RD:   state_reg <= ST_T_SQ;
                ST_T_SQ:   state_reg <= ST_T_ACC;
                ST_T_ACC:
                begin
                    if (i_reg == last_i)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_P_LO;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_T_RD;
                    end
                end
                ST_P_LO:   state_reg <= ST_P_HI;
                ST_P_HI:   state_reg <= ST_P_SUM;
                ST_P_SUM:  state_reg <= ST_S_RD;
                ST_S_RD:   state_reg <= ST_S_SQ;
                ST_S_SQ:   state_reg <= ST_S_ACC;
                ST_S_ACC:  state_reg <= ST_S_CMP;
                ST_S_CMP:
                begin
                    // Stop at the first running sum past the draw; none keeps index 0
                    if (exceeds)
                    begin
                        k_reg     <= i_addr;
                        i_reg     <= '0;
                        state_reg <= ST_C_WR;
                    end
                    else if (i_reg == last_i)
                    begin
                        k_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= ST_C_WR;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_S_RD;
                    end
                end
                ST_C_WR:
                begin
                    i_reg <= i_reg + CW'(1);
                    if (i_reg == last_i)
                        state_reg <= ST_DONE;
                end
                ST_Q_RD:   state_reg <= ST_Q_SQ;
                ST_Q_SQ:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    // Load the result beat when the output register frees up
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_idx_reg   <= (mode_reg == MODE_MEASURE) ? IDX_W'(k_reg) : '0;
                        res_prob_reg  <= (mode_reg == MODE_QUERY && pos_in) ? prob : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[src/grover_state_vector_engine.sv]
// One command at a time. A Hadamard takes each butterfly pair in turn: read both
// entries, multiply, write the sum, then write the difference.
// The next command is taken while the previous result beat still waits; it then
// stalls at its end until that beat is taken.
// rst_n clears control and sets qubit_count to 1; amplitudes hold no value until init.
module grover_state_vector_engine
    import gsv_pkg::*;
#(
    parameter int MAX_QUBITS    = DEF_MAX_QUBITS,
    parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    gsv_cmd_if.sink     cmd,
    gsv_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW_A = MAX_QUBITS;
    localparam int NW   = $clog2(MAX_QUBITS + 1);

    logic [NW-1:0]     eff_n;
    dp_cmd_t           dcmd;
    logic [AW_A-1:0]   rd_addr_a, rd_addr_b, wr_addr;
    logic [DRAW_W-1:0] draw;
    logic              exceeds;
    logic [PROB_W-1:0] prob;

    gsv_cfg #(.MAX_QUBITS(MAX_QUBITS)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_n   (eff_n)
    );

    gsv_ctrl #(.MAX_QUBITS(MAX_QUBITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .eff_n     (eff_n),
        .dcmd      (dcmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .draw      (draw),
        .exceeds   (exceeds),
        .prob      (prob)
    );

    gsv_dp #(.MAX_QUBITS(MAX_QUBITS), .AMP_FRAC_BITS(AMP_FRAC_BITS)) u_dp (
        .clk       (clk),
        .cmd       (dcmd),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_addr   (wr_addr),
        .eff_n     (eff_n),
        .draw      (draw),
        .exceeds   (exceeds),
        .prob      (prob)
    );

endmodule

[src/gsv_checker.sv]
// Port-level checker for the state-vector engine, bound to the top level.
// Depends on gsv_pkg and grover_state_vector_engine_assert.svh.
`include "grover_state_vector_engine_assert.svh"

module gsv_checker
    import gsv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic [IDX_W-1:0]  res_index,
    input logic [PROB_W-1:0] res_prob,
    input logic              pready
);

    logic [1:0] pend_reg;
    logic       cmd_beat, res_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign res_beat = res_valid && res_ready;

    // Track commands whose result beat is still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + 2'(cmd_beat) - 2'(res_beat);
    end

    `GSV_ASSERT_IMP(a_no_orphan_result, clk, rst_n, res_valid, pend_reg != 2'd0)
    `GSV_ASSERT_IMP(a_one_in_flight, clk, rst_n, cmd_beat, pend_reg == 2'd0 || pend_reg == 2'd1)
    `GSV_ASSERT_NXT(a_result_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_index) && $stable(res_prob))
    `GSV_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind grover_state_vector_engine gsv_checker u_gsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_index (res.measured_index),
    .res_prob  (res.probability),
    .pready    (pready)
);

[tb/testbench.sv]
// Self-checking testbench of the Grover state-vector engine: predictor, scoreboard, drivers.
// Depends on gsv_pkg, gsv_cmd_if, gsv_res_if and grover_state_vector_engine.
`timescale 1ns / 100ps

module testbench
    import gsv_pkg::*;
();

    localparam int          CLK_HALF     = 2;
    localparam int          CYCLE_LIMIT  = 1500000;
    localparam int          STORE_DEPTH  = 1 << DEF_MAX_QUBITS;
    localparam int          AMP_HI       = 32767;
    localparam int          AMP_LO       = -32768;
    localparam int          ONE_AMP      = 1 << DEF_AMP_FRAC_BITS;
    localparam logic [2:0]  MODE_SPARE_A = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B = 3'd7;
    localparam int          RANDOM_ITEMS = 75;
    localparam int          REPORT_MAX   = 10;

    typedef struct {
        logic [IDX_W-1:0]  measured_index;
        logic [PROB_W-1:0] probability;
    } outcome_t;

    // Predicts each result from its own copy of the amplitudes and the qubit count
    class state_vector_scoreboard;
        int              amp [STORE_DEPTH];
        logic [QC_W-1:0] qubits;
        int              written_size;
        outcome_t        pending_outcomes [$];
        int              mismatches;

        function new();
            qubits       = QC_RESET;
            written_size = 0;
            mismatches   = 0;
        endfunction

        function int clamp_amp(longint v);
            if (v > AMP_HI) return AMP_HI;
            if (v < AMP_LO) return AMP_LO;
            return int'(v);
        endfunction

        function int active_qubits();
            int n;
            n = qubits;
            if (n < 1) n = 1;
            if (n > DEF_MAX_QUBITS) n = DEF_MAX_QUBITS;
            return n;
        endfunction

        function int active_size();
            return 1 << active_qubits();
        endfunction

        function longint unsigned amp_square(int a);
            longint unsigned m;
            m = (a < 0) ? longint'(-a) : longint'(a);
            return m * m;
        endfunction

        // Integer square root rounded to nearest
        function longint unsigned rounded_root(longint unsigned x);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= root + bitv)
                begin
                    x    = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            if (x > root) root = root + 1;
            return root;
        endfunction

        function void note_command(logic [MODE_W-1:0] m, logic [POS_W-1:0] p,
                                   logic [DRAW_W-1:0] d);
            int              sz;
            int              h;
            int              k;
            int              v;
            longint          a;
            longint          b;
            longint unsigned total;
            longint unsigned run;
            logic [127:0]    lhs;
            logic [127:0]    rhs;
            outcome_t        o;
            sz = active_size();
            o.measured_index = '0;
            o.probability    = '0;
            case (m)
                MODE_INIT:
                begin
                    v = clamp_amp(longint'(rounded_root(64'd1 <<
                        (2 * DEF_AMP_FRAC_BITS - active_qubits()))));
                    for (int i = 0; i < sz; i++) amp[i] = v;
                    if (sz > written_size) written_size = sz;
                end
                MODE_HAD:
                begin
                    for (h = 1; h < sz; h = h << 1)
                        for (int i = 0; i < sz; i++)
                            if ((i & h) == 0)
                            begin
                                a = amp[i];
                                b = amp[i | h];
                                amp[i]     = clamp_amp(((a + b) * INV_SQRT2_Q16 + 32768) >>> 16);
                                amp[i | h] = clamp_amp(((a - b) * INV_SQRT2_Q16 + 32768) >>> 16);
                            end
                end
                MODE_ORACLE:
                begin
                    for (int i = 0; i < sz; i++)
                        amp[i] = clamp_amp(amp[i] < 0 ? -longint'(amp[i]) : longint'(amp[i]));
                    if (p < sz) amp[p] = clamp_amp(-longint'(amp[p]));
                end
                MODE_PHASE:
                    for (int i = 1; i < sz; i++) amp[i] = clamp_amp(-longint'(amp[i]));
                MODE_MEASURE:
                begin
                    total = 0;
                    run   = 0;
                    k     = 0;
                    for (int i = 0; i < sz; i++) total += amp_square(amp[i]);
                    if (total != 0)
                        for (int i = 0; i < sz; i++)
                        begin
                            run += amp_square(amp[i]);
                            lhs = {64'd0, run} << 32;
                            rhs = 128'(d) * 128'(total);
                            if (lhs > rhs)
                            begin
                                k = i;
                                break;
                            end
                        end
                    for (int i = 0; i < sz; i++) amp[i] = 0;
                    amp[k] = ONE_AMP;
                    o.measured_index = IDX_W'(k);
                end
                MODE_QUERY:
                    if (p < sz)
                    begin
                        total = amp_square(amp[p]);
                        o.probability = (total > PROB_MAX) ? PROB_MAX : PROB_W'(total);
                    end
                default:
                    ;
            endcase
            pending_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [IDX_W-1:0] idx, logic [PROB_W-1:0] prob);
            outcome_t e;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: index %0d probability %0d", idx, prob);
                return;
            end
            e = pending_outcomes.pop_front();
            if (idx !== e.measured_index || prob !== e.probability)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result mismatch: index exp %0d got %0d, probability exp %0d got %0d",
                             e.measured_index, idx, e.probability, prob);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int cycle_count;
    int items_sent;

    state_vector_scoreboard sb;

    gsv_cmd_if cmd_bus ();
    gsv_res_if res_bus ();

    grover_state_vector_engine u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .res     (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("grover_state_vector_engine test failed");
                $finish;
            end
        end
    end

    // Drive result ready; hold it low while a long hold-off is pending
    initial
    begin
        res_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_bus.ready = 1'b0;
                hold_left--;
            end
            else
                res_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check every accepted result beat
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
                sb.check_outcome(res_bus.measured_index, res_bus.probability);
        end
    end

    // Write the qubit count, then read it back
    task automatic write_qubits(logic [QC_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'({REG_QUBIT_COUNT, 2'b00});
        pwdata  = 32'(val);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.qubits = val;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[QC_W-1:0] !== val)
        begin
            sb.mismatches++;
            if (sb.mismatches <= REPORT_MAX)
                $display("qubit count readback: exp %0d got %0d", val, prdata[QC_W-1:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Offer one command beat; a command that would read unwritten entries becomes init
    task automatic issue(logic [MODE_W-1:0] m, logic [POS_W-1:0] p, logic [DRAW_W-1:0] d);
        if (m >= MODE_HAD && m <= MODE_QUERY && sb.written_size < sb.active_size())
            m = MODE_INIT;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid       = 1'b1;
        cmd_bus.mode        = m;
        cmd_bus.position    = p;
        cmd_bus.random_draw = d;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        sb.note_command(m, p, d);
        items_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
    endtask

    // Wait for every result, then let the block settle
    task automatic drain();
        drop_valid();
        while (sb.pending_outcomes.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 75)
            return POS_W'($urandom & (sb.active_size() - 1));
        return POS_W'($urandom);
    endfunction

    // One search: init, Hadamard, a few Grover iterations, then readout
    task automatic grover_search();
        logic [POS_W-1:0] target;
        int               iters;
        target = pick_position();
        iters  = $urandom_range(1, 2);
        issue(MODE_INIT, POS_W'($urandom), $urandom);
        issue(MODE_HAD, POS_W'($urandom), $urandom);
        repeat (iters)
        begin
            issue(MODE_ORACLE, target, $urandom);
            issue(MODE_HAD, POS_W'($urandom), $urandom);
            issue(MODE_PHASE, POS_W'($urandom), $urandom);
            issue(MODE_HAD, POS_W'($urandom), $urandom);
        end
        issue(MODE_QUERY, target, $urandom);
        issue(MODE_MEASURE, POS_W'($urandom), $urandom);
        issue(MODE_QUERY, pick_position(), $urandom);
    endtask

    task automatic random_noise();
        issue(MODE_W'($urandom_range(0, 7)), pick_position(), $urandom);
    endtask

    initial
    begin
        logic [QC_W-1:0] plan [8];
        int              quota;
        sb                  = new();
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.mode        = MODE_INIT;
        cmd_bus.position    = '0;
        cmd_bus.random_draw = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_left           = 0;
        items_sent          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(posedge clk);

        // Directed: every mode, extremes of the fields, out-of-range cases
        write_qubits(QC_W'(2));
        issue(MODE_INIT, '0, '0);
        issue(MODE_QUERY, '0, '0);
        issue(MODE_QUERY, POS_W'(3), '1);
        issue(MODE_QUERY, '1, '0);
        issue(MODE_HAD, '1, '1);
        issue(MODE_QUERY, '0, '0);
        issue(MODE_ORACLE, POS_W'(3), '0);
        issue(MODE_ORACLE, '1, '0);
        issue(MODE_PHASE, '0, '0);
        issue(MODE_HAD, '0, '0);
        issue(MODE_QUERY, POS_W'(3), '0);
        issue(MODE_MEASURE, '0, '0);
        issue(MODE_MEASURE, '0, '1);
        issue(MODE_SPARE_A, '1, '1);
        issue(MODE_SPARE_B, '1, '1);
        drain();
        // Shrink the count after init: stored entries stay
        write_qubits(QC_W'(1));
        issue(MODE_HAD, '0, '0);
        issue(MODE_QUERY, POS_W'(1), '0);
        issue(MODE_PHASE, '0, '0);
        issue(MODE_MEASURE, '0, 32'h8000_0000);
        drain();
        // Zero acts as one qubit
        write_qubits(QC_W'(0));
        issue(MODE_INIT, '0, '0);
        issue(MODE_QUERY, POS_W'(1), '0);
        issue(MODE_QUERY, POS_W'(2), '0);
        drain();
        // Init and Hadamard at three qubits, then measure at one and again at three
        write_qubits(QC_W'(3));
        issue(MODE_INIT, '0, '0);
        issue(MODE_HAD, '0, '0);
        drain();
        write_qubits(QC_W'(1));
        drain();
        issue(MODE_MEASURE, '0, '1);
        drain();
        write_qubits(QC_W'(3));
        issue(MODE_MEASURE, '0, '1);
        issue(MODE_QUERY, '0, '0);
        drain();

        // Random searches over several counts and idling patterns
        plan = '{QC_W'(2), QC_W'(3), QC_W'(1), QC_W'(4), QC_W'(15), QC_W'(5), QC_W'(2),
                 QC_W'(10)};
        items_sent = 0;
        for (int ph = 0; ph < 8 || items_sent < RANDOM_ITEMS; ph++)
        begin
            write_qubits(plan[ph % 8]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            if (ph == 1)
            begin
                send_idle_pct = 0;
                @(posedge clk);
                hold_left = 400;
            end
            quota = (sb.active_qubits() >= 8) ? 6 : 8;
            quota = items_sent + quota;
            while (items_sent < quota)
            begin
                if ($urandom_range(0, 99) < 70 && sb.active_qubits() < 8)
                    grover_search();
                else
                    random_noise();
            end
            drain();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        drain();
        repeat (64) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
            $display("grover_state_vector_engine test passed");
        else
            $display("grover_state_vector_engine test failed");
        $finish;
    end

endmodule
